FILE: rtl/sh13_pkg.sv
// sh13_pkg: shared types and constants of the siphash-1-3 keyed hash core
// used by the front end, the command queue, the round engine and the top level
`default_nettype none
package sh13_pkg;

   // datapath widths
   localparam int WORD_W   = 64;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 8;
   localparam int POS_W    = 3;
   localparam int CSR_IDX_W = 2;

   // command queue depth
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int CMD_CNT_W = 3;

   // number of finalization rounds
   localparam int FINAL_ROUNDS = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 2'd1;

   // lane initialization constants
   localparam logic [WORD_W-1:0] INIT_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   // one unit of work for the round engine
   typedef struct packed {
      logic              first;    // message opens: load lanes from the key
      logic              full;     // word holds eight message bytes
      logic              is_last;  // message ends after this word
      logic [WORD_W-1:0] word;     // complete word or partial tail
      logic [LEN_W-1:0]  length;   // message length mod 256
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/sh13_front.sv
// sh13_front: accepts message bytes, packs them little-endian into words
// and emits word commands into the command queue; uses sh13_pkg
`default_nettype none
module sh13_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [sh13_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                       req_byte_present,
   input  wire logic                       req_last,
   output logic                            cmd_push,
   output sh13_pkg::cmd_type               cmd_data,
   input  wire logic                       cmd_full
);
   import sh13_pkg::*;

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              first_ff, first_in;

   logic              accept;
   logic [WORD_W-1:0] acc_with;
   logic [LEN_W-1:0]  len_with;
   logic              word_full;

   // a request is taken whenever the queue has room
   assign req_full = cmd_full;
   assign accept   = req_push & ~cmd_full;

   // merge the new byte into the partial word
   always_comb begin
      acc_with = acc_ff;
      if (req_byte_present) begin
         acc_with[pos_ff*BYTE_W +: BYTE_W] = req_data_byte;
      end
      len_with  = len_ff + LEN_W'(req_byte_present);
      word_full = req_byte_present & (pos_ff == {POS_W{1'b1}});
   end

   // build the command and the next packing state
   always_comb begin
      cmd_push         = accept & (word_full | req_last);
      cmd_data.first   = first_ff;
      cmd_data.full    = word_full;
      cmd_data.is_last = req_last;
      cmd_data.word    = acc_with;
      cmd_data.length  = len_with;

      acc_in   = acc_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      first_in = first_ff;
      if (accept & (req_byte_present | req_last)) begin
         acc_in = (word_full | req_last) ? '0 : acc_with;
         pos_in = req_last ? '0 : pos_ff + POS_W'(req_byte_present);
         len_in = req_last ? '0 : len_with;
      end
      if (cmd_push) begin
         first_in = req_last;
      end
   end

   // packing state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         first_ff <= first_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sh13_cmd_fifo.sv
// sh13_cmd_fifo: short queue of word commands between front end and round engine
// uses sh13_pkg for the command type and depth
`default_nettype none
module sh13_cmd_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sh13_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output sh13_pkg::cmd_type      pop_data,
   output logic                   empty
);
   import sh13_pkg::*;

   cmd_type              slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + CMD_PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + CMD_PTR_W'(do_pop);
      count_in  = count_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sh13_back.sv
// sh13_back: round engine, one half sipround per cycle unless held by a full result register, plus the result register
// uses sh13_pkg for the command type and lane constants
`default_nettype none
module sh13_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [sh13_pkg::WORD_W-1:0] key_lo,
   input  wire logic [sh13_pkg::WORD_W-1:0] key_hi,
   input  wire sh13_pkg::cmd_type           cmd_data,
   input  wire logic                        cmd_empty,
   output logic                             cmd_pop,
   output logic [sh13_pkg::WORD_W-1:0]      rsp_hash_value,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop
);
   import sh13_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
   } lanes_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ABS_A = 5'b00010,
      S_ABS_B = 5'b00100,
      S_FIN_A = 5'b01000,
      S_FIN_B = 5'b10000
   } state_type;

   localparam logic [1:0] LAST_FIN = 2'(FINAL_ROUNDS - 1);

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   // first half of a sipround: one add level per lane pair
   function automatic lanes_type half_a(input lanes_type l);
      lanes_type o;
      o.v0 = l.v0 + l.v1;
      o.v1 = rotl(l.v1, 13) ^ o.v0;
      o.v0 = rotl(o.v0, 32);
      o.v2 = l.v2 + l.v3;
      o.v3 = rotl(l.v3, 16) ^ o.v2;
      return o;
   endfunction

   // second half of a sipround
   function automatic lanes_type half_b(input lanes_type l);
      lanes_type o;
      o.v0 = l.v0 + l.v3;
      o.v3 = rotl(l.v3, 21) ^ o.v0;
      o.v2 = l.v2 + l.v1;
      o.v1 = rotl(l.v1, 17) ^ o.v2;
      o.v2 = rotl(o.v2, 32);
      return o;
   endfunction

   state_type         state_ff, state_in;
   lanes_type         lanes_ff, lanes_in;
   logic [WORD_W-1:0] msg_ff, msg_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              second_ff, second_in;
   logic              fin_ff, fin_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic              valid_ff, valid_in;

   lanes_type         init_lanes, a_src, ha, hb;
   logic [WORD_W-1:0] tail_word;
   logic              out_free;

   assign rsp_hash_value = hash_ff;
   assign rsp_empty      = ~valid_ff;
   assign out_free       = ~valid_ff | rsp_pop;
   assign tail_word      = {len_ff, {(WORD_W-LEN_W){1'b0}}};

   // key-derived starting lanes
   always_comb begin
      init_lanes.v0 = key_lo ^ INIT_C0;
      init_lanes.v1 = key_hi ^ INIT_C1;
      init_lanes.v2 = key_lo ^ INIT_C2;
      init_lanes.v3 = key_hi ^ INIT_C3;
   end

   // round datapath: message xor into v3 on absorb, 0xff into v2 before finalization
   always_comb begin
      a_src = lanes_ff;
      if (state_ff == S_ABS_A) begin
         a_src.v3 = lanes_ff.v3 ^ msg_ff;
      end
      if ((state_ff == S_FIN_A) && (cnt_ff == '0)) begin
         a_src.v2 = lanes_ff.v2 ^ FINAL_XOR;
      end
      ha = half_a(a_src);
      hb = half_b(lanes_ff);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      lanes_in  = lanes_ff;
      msg_in    = msg_ff;
      len_in    = len_ff;
      second_in = second_ff;
      fin_in    = fin_ff;
      cnt_in    = cnt_ff;
      hash_in   = hash_ff;
      valid_in  = valid_ff & ~rsp_pop;
      cmd_pop   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               lanes_in  = cmd_data.first ? init_lanes : lanes_ff;
               msg_in    = cmd_data.full ? cmd_data.word
                         : cmd_data.word | {cmd_data.length, {(WORD_W-LEN_W){1'b0}}};
               len_in    = cmd_data.length;
               second_in = cmd_data.full & cmd_data.is_last;
               fin_in    = cmd_data.is_last;
               state_in  = S_ABS_A;
            end
         end
         S_ABS_A: begin
            lanes_in = ha;
            state_in = S_ABS_B;
         end
         S_ABS_B: begin
            lanes_in    = hb;
            lanes_in.v0 = hb.v0 ^ msg_ff;
            if (second_ff) begin
               // word boundary hit on the last byte: absorb the length-only word
               msg_in    = tail_word;
               second_in = 1'b0;
               state_in  = S_ABS_A;
            end else if (fin_ff) begin
               cnt_in   = '0;
               state_in = S_FIN_A;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIN_A: begin
            lanes_in = ha;
            state_in = S_FIN_B;
         end
         S_FIN_B: begin
            if (cnt_ff == LAST_FIN) begin
               // hold here until the result register is free
               if (out_free) begin
                  lanes_in = hb;
                  hash_in  = hb.v0 ^ hb.v1 ^ hb.v2 ^ hb.v3;
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               lanes_in = hb;
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_FIN_A;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
         fin_ff    <= 1'b0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         fin_ff    <= fin_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
      end
   end

   // lanes, message word and result
   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      msg_ff   <= msg_in;
      len_ff   <= len_in;
      hash_ff  <= hash_in;
   end

endmodule
`default_nettype wire

FILE: rtl/siphash_1_3_keyed_hash_core.sv
// siphash_1_3_keyed_hash_core: top level with key registers and the three sub-blocks
// depends on sh13_pkg, sh13_front, sh13_cmd_fifo and sh13_back
//
// Usage: message bytes enter one per request on the req_ queue port (push/full).
// req_byte_present marks a real byte; req_last closes the message, and a request
// with no byte and req_last set closes it without adding one (empty message).
// A request with neither flag is taken and ignored.
// The 64-bit digest of each message leaves on the rsp_ queue port (empty/pop).
// The key is written through the csr_ port (index 0 low half, index 1 high half),
// always ready; write it only while no message is in flight.
// Throughput: one byte per cycle while the four-entry command queue has room.
// The round engine runs one half sipround per cycle; each word passes through the idle
// state and the two absorb halves, and a message end adds three final rounds (and a
// second absorb of the length-only word when the last byte also completes a word).
// A stalled receiver holds one digest in the result register; the engine then
// waits at its last round while the queue keeps taking requests until it fills.
// Reset (synchronous, active high) clears the key to zero, empties the queue,
// drops any partial message and any undelivered digest.
`default_nettype none
module siphash_1_3_keyed_hash_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [sh13_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                           req_byte_present,
   input  wire logic                           req_last,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [sh13_pkg::WORD_W-1:0]         rsp_hash_value,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sh13_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sh13_pkg::WORD_W-1:0]    csr_wdata
);
   import sh13_pkg::*;

   logic [WORD_W-1:0] key_lo_ff, key_lo_in;
   logic [WORD_W-1:0] key_hi_ff, key_hi_in;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wr, cmd_rd;

   // key registers, writes to unknown indexes are dropped
   assign csr_ready = 1'b1;
   always_comb begin
      key_lo_in = key_lo_ff;
      key_hi_in = key_hi_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_LO: key_lo_in = csr_wdata;
            CSR_KEY_HI: key_hi_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff <= '0;
         key_hi_ff <= '0;
      end else begin
         key_lo_ff <= key_lo_in;
         key_hi_ff <= key_hi_in;
      end
   end

   // byte packing front end
   sh13_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wr),
      .cmd_full         (cmd_full)
   );

   // command queue
   sh13_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   // round engine and result register
   sh13_back u_back (
      .clock          (clock),
      .reset          (reset),
      .key_lo         (key_lo_ff),
      .key_hi         (key_hi_ff),
      .cmd_data       (cmd_rd),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .rsp_hash_value (rsp_hash_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop)
   );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: self-checking bench for the siphash-1-3 keyed hash core, byte requests in, digests out
// depends on sh13_pkg and siphash_1_3_keyed_hash_core; a local digest predictor checks every result
`timescale 1ns / 1ps
module tb_top;
   import sh13_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 24;
   localparam int ITEMS_PER_MODE = 190;

   // register indexes past the two key halves, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
   } lanes_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              present;
      logic              is_last;
      logic              hold;     // wait for all digests before offering this one
   } byte_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 req_byte_present = 1'b0;
   logic                 req_last = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [WORD_W-1:0]    rsp_hash_value;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // predictor copy of the key and of the hash state
   logic [WORD_W-1:0] key_lo = '0;
   logic [WORD_W-1:0] key_hi = '0;
   lanes_type         lanes = '0;
   logic [WORD_W-1:0] word_acc = '0;
   logic [POS_W-1:0]  byte_pos = '0;
   logic [LEN_W-1:0]  msg_len = '0;
   logic              msg_open = 1'b0;

   byte_req_type      byte_reqs[$];
   logic [WORD_W-1:0] digests[$];

   int send_idle_pct = 32;
   int recv_idle_pct = 59;
   int n_errors = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_key_writes = 0;
   int queued_bytes = 0;
   int cycle_count = 0;

   siphash_1_3_keyed_hash_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic lanes_type sip_round(input lanes_type s);
      s.v0 += s.v1;
      s.v1 = rotl(s.v1, 13) ^ s.v0;
      s.v0 = rotl(s.v0, 32);
      s.v2 += s.v3;
      s.v3 = rotl(s.v3, 16) ^ s.v2;
      s.v0 += s.v3;
      s.v3 = rotl(s.v3, 21) ^ s.v0;
      s.v2 += s.v1;
      s.v1 = rotl(s.v1, 17) ^ s.v2;
      s.v2 = rotl(s.v2, 32);
      return s;
   endfunction

   function automatic lanes_type absorb_word(input lanes_type s, input logic [WORD_W-1:0] m);
      s.v3 ^= m;
      s = sip_round(s);
      s.v0 ^= m;
      return s;
   endfunction

   // digest predictor, advanced once per accepted request
   task automatic absorb_request(input logic [BYTE_W-1:0] b, input logic present,
                                 input logic fin);
      logic [WORD_W-1:0] tail;
      if (!present && !fin)
         return;
      // lanes come from the key on the first request of a message
      if (!msg_open) begin
         lanes.v0 = key_lo ^ INIT_C0;
         lanes.v1 = key_hi ^ INIT_C1;
         lanes.v2 = key_lo ^ INIT_C2;
         lanes.v3 = key_hi ^ INIT_C3;
         word_acc = '0;
         byte_pos = '0;
         msg_len = '0;
         msg_open = 1'b1;
      end
      if (present) begin
         word_acc |= {{(WORD_W-BYTE_W){1'b0}}, b} << {byte_pos, 3'b000};
         byte_pos++;
         msg_len++;
         if (byte_pos == 0) begin
            lanes = absorb_word(lanes, word_acc);
            word_acc = '0;
         end
      end
      if (fin) begin
         tail = word_acc | {msg_len, {(WORD_W-LEN_W){1'b0}}};
         lanes = absorb_word(lanes, tail);
         lanes.v2 ^= FINAL_XOR;
         for (int r = 0; r < FINAL_ROUNDS; r++)
            lanes = sip_round(lanes);
         digests.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
         msg_open = 1'b0;
      end
   endtask

   // every queued request counts toward the per-mode budget, idle ones too
   task automatic add_req(input logic [BYTE_W-1:0] b, input logic present, input logic fin,
                          input logic hold);
      byte_req_type r;
      r.data = b;
      r.present = present;
      r.is_last = fin;
      r.hold = hold;
      byte_reqs.push_back(r);
      queued_bytes++;
   endtask

   // one message of random bytes, with idle requests sprinkled in as noise
   task automatic queue_message(input int len, input bit marker_end, input bit force_hold);
      int hold_at;
      hold_at = -1;
      if (force_hold || $urandom_range(0, 19) == 0)
         hold_at = $urandom_range(0, (len > 0) ? len - 1 : 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_req(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
         add_req(BYTE_W'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !marker_end,
                 i == hold_at);
      end
      if (marker_end || len == 0)
         add_req(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1, (len == 0) && (hold_at == 0));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_KEY_LO)
         key_lo = val;
      else if (idx == CSR_KEY_HI)
         key_hi = val;
      n_key_writes++;
   endtask

   // wait until every request is taken and every digest is back, then let the engine settle
   task automatic wait_drained();
      do
         @(negedge clock);
      while (byte_reqs.size() != 0 || req_push || digests.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            absorb_request(req_data_byte, req_byte_present, req_last);
            n_requests++;
         end
         if (!req_push || !req_full) begin
            if (byte_reqs.size() != 0 && !(byte_reqs[0].hold && digests.size() != 0) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data_byte <= byte_reqs[0].data;
               req_byte_present <= byte_reqs[0].present;
               req_last <= byte_reqs[0].is_last;
               void'(byte_reqs.pop_front());
            end else begin
               req_push <= 1'b0;
               req_data_byte <= BYTE_W'($urandom_range(0, 255));
               req_byte_present <= 1'($urandom_range(0, 1));
               req_last <= 1'($urandom_range(0, 1));
            end
         end
      end
   end

   // digest monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (digests.size() == 0) begin
               $display("%0t: unexpected digest %h with none pending", $time, rsp_hash_value);
               n_errors++;
            end else begin
               if (rsp_hash_value !== digests[0]) begin
                  $display("%0t: digest mismatch: expected %h actual %h",
                           $time, digests[0], rsp_hash_value);
                  n_errors++;
               end
               void'(digests.pop_front());
               n_checked++;
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d requests and %0d digests outstanding",
                  $time, byte_reqs.size(), digests.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, zero key: empty message, idle request, single-byte message, exact word
      write_csr(CSR_KEY_LO, '0);
      write_csr(CSR_KEY_HI, '0);
      add_req(8'h5a, 1'b0, 1'b1, 1'b0);
      add_req(8'hff, 1'b0, 1'b0, 1'b0);
      add_req(8'hff, 1'b1, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++)
         add_req(BYTE_W'(i), 1'b1, i == 7, 1'b0);
      wait_drained();

      // directed, all-ones key: seven bytes closed by an end marker, then a zero byte
      write_csr(CSR_KEY_LO, '1);
      write_csr(CSR_KEY_HI, '1);
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, '1);
      for (int i = 0; i < 7; i++)
         add_req(8'hf8 + BYTE_W'(i), 1'b1, 1'b0, 1'b0);
      add_req(8'h00, 1'b0, 1'b1, 1'b0);
      add_req(8'h00, 1'b1, 1'b1, 1'b0);
      wait_drained();

      // random messages under three stall profiles and three keys
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 59 : 0;
         recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 32 : 0;
         if (mode == 0) begin
            write_csr(CSR_KEY_LO, {32{2'b01}});
            write_csr(CSR_KEY_HI, {32{2'b10}});
         end else begin
            write_csr(CSR_KEY_HI, (mode == 2) ? '0 : {$urandom, $urandom});
            write_csr(CSR_KEY_LO, {$urandom, $urandom});
         end
         write_csr((mode == 1) ? CSR_SPARE_HI : CSR_SPARE_LO, {$urandom, $urandom});
         queued_bytes = 0;
         for (int m = 0; queued_bytes < ITEMS_PER_MODE; m++) begin
            int len;
            // one long message in the unstalled pass so the length byte wraps
            if (mode == 2 && m == 0)
               len = 256 + $urandom_range(1, 40);
            else if ($urandom_range(0, 9) == 0)
               len = $urandom_range(17, 48);
            else
               len = $urandom_range(0, 17);
            queue_message(len, $urandom_range(0, 3) == 0, m == 1);
         end
         wait_drained();
      end

      if (digests.size() != 0)
         $display("%0d digests never arrived", digests.size());
      $display("run covered %0d requests and %0d digests under %0d register writes",
               n_requests, n_checked, n_key_writes);
      $display("with extreme and random keys, empty and long messages, stalls on both sides");
      if (n_errors == 0 && digests.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
